[sv/cdt_pkg.sv]
// ============================================================================
// Chamfer distance transform package
// Shared request codes, sequencer states, store sizes and status types.
// ============================================================================
package cdt_pkg;

    // Store geometry and distance width.
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int DIST_BITS  = 16;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_RUN   = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        REG_WIDTH  = 3'd0,
        REG_HEIGHT = 3'd1,
        REG_ORTH   = 3'd2,
        REG_DIAG   = 3'd3,
        REG_KNIGHT = 3'd4,
        REG_MAXD   = 3'd5
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BORDER,
        ST_CENTRE,
        ST_NEIGH,
        ST_WRITE,
        ST_DONE
    } state_t;

    // Phase of a run: 0 near border, 1 forward, 2 far border, 3 backward.
    typedef logic [1:0] phase_t;

    localparam phase_t PH_NEAR = 2'd0;
    localparam phase_t PH_FWD  = 2'd1;
    localparam phase_t PH_FAR  = 2'd2;
    localparam phase_t PH_BWD  = 2'd3;

    localparam int NUM_NEIGH = 8;

    typedef struct packed {
        logic busy;
        logic done;
    } seq_status_t;

endpackage

[sv/chamfer_distance_transform_5x5.sv]
// ============================================================================
// Chamfer distance transform, 5x5 mask
// Stores an image in one synchronous RAM and runs the two-pass chamfer
// transform on it in place.
// ============================================================================
//  channel   | direction | transaction
//  s_axis    | in        | tdata = {pixel_value, y_pos, x_pos}, tuser = req_type
//  m_axis    | out       | tdata = read_value, tuser = is_done
//  cfg       | in        | cfg_index selects a register, cfg_data is written
//
//  A write is taken every cycle. A read result is registered in rd_pend_reg,
//  then out_valid_reg; input is held off until it is taken, so no new read is
//  accepted before the last result is taken. A run uses the single RAM read
//  port: a border pixel is read in ST_BORDER and written in ST_WRITE; an interior
//  pixel per pass takes a centre read, neighbour reads and a write. Input is held
//  off while a run or a pending result is in flight. RAM is not cleared by reset.
// ============================================================================
module chamfer_distance_transform_5x5 (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [31:0]               s_axis_tdata,  // x_pos[7:0], y_pos[15:8], pixel_value[31:16]
    input  logic [1:0]                s_axis_tuser,  // req_type
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [15:0]               m_axis_tdata,  // read_value
    output logic                      m_axis_tuser,  // is_done
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [2:0]                cfg_index,
    input  logic [15:0]               cfg_data
);
    import cdt_pkg::*;

    localparam int XB = $clog2(MAX_WIDTH);
    localparam int YB = $clog2(MAX_HEIGHT);
    localparam int AB = XB + YB;
    localparam int CB = XB + 2;  // signed coordinate width
    localparam int RB = YB + 2;
    localparam logic [DIST_BITS-1:0] DMAX = {DIST_BITS{1'b1}};

    // Configuration registers
    logic [8:0]  width_reg, height_reg;
    logic [7:0]  orth_reg, diag_reg, knight_reg;
    logic [15:0] maxd_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 9'd256;
            height_reg <= 9'd256;
            orth_reg   <= 8'd5;
            diag_reg   <= 8'd7;
            knight_reg <= 8'd11;
            maxd_reg   <= 16'd32000;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data[8:0];
                REG_HEIGHT: height_reg <= cfg_data[8:0];
                REG_ORTH:   orth_reg   <= cfg_data[7:0];
                REG_DIAG:   diag_reg   <= cfg_data[7:0];
                REG_KNIGHT: knight_reg <= cfg_data[7:0];
                REG_MAXD:   maxd_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Clamped sizes
    logic [12:0] w_eff, h_eff;
    always_comb
    begin
        if (width_reg < 9'd5)
            w_eff = 13'd5;
        else if (13'(width_reg) > 13'(MAX_WIDTH))
            w_eff = 13'(MAX_WIDTH);
        else
            w_eff = 13'(width_reg);
        if (height_reg < 9'd5)
            h_eff = 13'd5;
        else if (13'(height_reg) > 13'(MAX_HEIGHT))
            h_eff = 13'(MAX_HEIGHT);
        else
            h_eff = 13'(height_reg);
    end

    // Saturated constants
    logic [DIST_BITS-1:0] wo_sat, maxd_sat;
    assign wo_sat   = (32'(orth_reg) > 32'(DMAX)) ? DMAX : DIST_BITS'(orth_reg);
    assign maxd_sat = (32'(maxd_reg) > 32'(DMAX)) ? DMAX : DIST_BITS'(maxd_reg);

    // Image RAM
    logic [DIST_BITS-1:0] ram [0:MAX_WIDTH*MAX_HEIGHT-1];
    logic                 ram_we;
    logic [AB-1:0]        ram_waddr, ram_raddr;
    logic [DIST_BITS-1:0] ram_wdata, ram_rdata;

    always_ff @(posedge clk)
    begin
        if (ram_we)
            ram[ram_waddr] <= ram_wdata;
        ram_rdata <= ram[ram_raddr];
    end

    // Sequencer
    state_t   state_reg, state_next;
    phase_t   phase_reg, phase_next;
    logic signed [CB-1:0] x_reg, x_next;
    logic signed [RB-1:0] y_reg, y_next;
    logic [3:0] nidx_reg, nidx_next;
    logic [DIST_BITS+1:0] min_reg, min_next;
    logic                 cen_nz_reg, cen_nz_next;
    logic                 pend_reg, pend_next;  // neighbour read in flight
    logic [3:0]           pidx_reg, pidx_next;

    // Output register
    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_data_reg, out_data_next;
    logic        out_done_reg, out_done_next;
    logic        rd_pend_reg, rd_pend_next;
    logic        rd_in_reg, rd_in_next;

    seq_status_t status;
    assign status.busy = (state_reg != ST_IDLE);
    assign status.done = (state_reg == ST_DONE);

    logic in_acc;
    assign s_axis_tready = !status.busy && !rd_pend_reg && !out_valid_reg;
    assign in_acc = s_axis_tvalid && s_axis_tready;

    logic [1:0] req;
    logic [7:0] in_x, in_y;
    assign req  = s_axis_tuser;
    assign in_x = s_axis_tdata[7:0];
    assign in_y = s_axis_tdata[15:8];

    logic in_inside;
    assign in_inside = (32'(in_x) < 32'(MAX_WIDTH)) && (32'(in_y) < 32'(MAX_HEIGHT));

    // Neighbour offsets of the forward mask; backward mirrors them.
    logic signed [2:0] dx, dy;
    always_comb
    begin
        case (nidx_reg[2:0])
            3'd0:    begin dx = -3'sd1; dy =  3'sd0; end
            3'd1:    begin dx = -3'sd2; dy = -3'sd1; end
            3'd2:    begin dx = -3'sd1; dy = -3'sd1; end
            3'd3:    begin dx =  3'sd0; dy = -3'sd1; end
            3'd4:    begin dx =  3'sd1; dy = -3'sd1; end
            3'd5:    begin dx =  3'sd2; dy = -3'sd1; end
            3'd6:    begin dx = -3'sd1; dy = -3'sd2; end
            default: begin dx =  3'sd1; dy = -3'sd2; end
        endcase
    end

    logic [7:0] pw;
    always_comb
    begin
        case (pidx_reg[2:0])
            3'd0, 3'd3:       pw = orth_reg;
            3'd2, 3'd4:       pw = diag_reg;
            default:          pw = knight_reg;
        endcase
    end

    logic signed [CB-1:0] nx;
    logic signed [RB-1:0] ny;
    always_comb
    begin
        if (phase_reg == PH_BWD)
        begin
            nx = x_reg - CB'(dx);
            ny = y_reg - RB'(dy);
        end
        else
        begin
            nx = x_reg + CB'(dx);
            ny = y_reg + RB'(dy);
        end
    end

    // Candidate from the neighbour read that returned this cycle
    logic [DIST_BITS+1:0] cand;
    assign cand = (DIST_BITS+2)'(ram_rdata) + (DIST_BITS+2)'(pw);

    // Loop bounds
    logic signed [CB-1:0] w_s;
    logic signed [RB-1:0] h_s;
    assign w_s = CB'(w_eff);
    assign h_s = RB'(h_eff);

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        nidx_next   = nidx_reg;
        min_next    = min_reg;
        cen_nz_next = cen_nz_reg;
        pend_next   = 1'b0;
        pidx_next   = nidx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && req == REQ_RUN)
                begin
                    state_next = ST_BORDER;
                    phase_next = PH_NEAR;
                    x_next     = CB'(1);
                    y_next     = RB'(1);
                end
            end
            ST_BORDER:
            begin
                // Read the border pixel; its value arrives in ST_WRITE.
                state_next = ST_WRITE;
            end
            ST_CENTRE:
            begin
                state_next = ST_NEIGH;
                nidx_next  = 4'd0;
            end
            ST_NEIGH:
            begin
                if (nidx_reg == 4'd0)
                begin
                    cen_nz_next = (ram_rdata != '0);
                    min_next    = (phase_reg == PH_FWD) ? (DIST_BITS+2)'(maxd_sat)
                                                       : (DIST_BITS+2)'(ram_rdata);
                end
                else if (pend_reg && cand < min_reg)
                    min_next = cand;
                if (nidx_reg == 4'(NUM_NEIGH))
                    state_next = ST_WRITE;
                else
                begin
                    pend_next = 1'b1;
                    nidx_next = nidx_reg + 4'd1;
                end
            end
            ST_WRITE:
            begin
                // Advance position and phase.
                state_next = ST_BORDER;
                case (phase_reg)
                    PH_NEAR:
                    begin
                        if (x_reg == CB'(1) && y_reg < h_s - RB'(2))
                            y_next = y_reg + RB'(1);
                        else if (x_reg == CB'(1))
                        begin
                            x_next = CB'(2);
                            y_next = RB'(1);
                        end
                        else if (x_reg < w_s - CB'(2))
                            x_next = x_reg + CB'(1);
                        else
                        begin
                            phase_next = PH_FWD;
                            x_next     = CB'(2);
                            y_next     = RB'(2);
                            state_next = ST_CENTRE;
                        end
                    end
                    PH_FWD:
                    begin
                        state_next = ST_CENTRE;
                        if (x_reg < w_s - CB'(3))
                            x_next = x_reg + CB'(1);
                        else if (y_reg < h_s - RB'(3))
                        begin
                            x_next = CB'(2);
                            y_next = y_reg + RB'(1);
                        end
                        else
                        begin
                            phase_next = PH_FAR;
                            x_next     = w_s - CB'(2);
                            y_next     = h_s - RB'(2);
                            state_next = ST_BORDER;
                        end
                    end
                    PH_FAR:
                    begin
                        if (x_reg == w_s - CB'(2) && y_reg > RB'(2))
                            y_next = y_reg - RB'(1);
                        else if (x_reg == w_s - CB'(2))
                        begin
                            x_next = w_s - CB'(3);
                            y_next = h_s - RB'(2);
                        end
                        else if (x_reg > CB'(2))
                            x_next = x_reg - CB'(1);
                        else
                        begin
                            phase_next = PH_BWD;
                            x_next     = w_s - CB'(3);
                            y_next     = h_s - RB'(3);
                            state_next = ST_CENTRE;
                        end
                    end
                    default:
                    begin
                        state_next = ST_CENTRE;
                        if (x_reg > CB'(2))
                            x_next = x_reg - CB'(1);
                        else if (y_reg > RB'(2))
                        begin
                            x_next = w_s - CB'(3);
                            y_next = y_reg - RB'(1);
                        end
                        else
                            state_next = ST_DONE;
                    end
                endcase
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Sizes are clamped to at least 5, so the interior is never empty.
    // (width 5 gives one interior column; both passes cover it.)

    // RAM address and write control
    logic [XB-1:0] ax;
    logic [YB-1:0] ay;
    always_comb
    begin
        ram_we    = 1'b0;
        ram_wdata = s_axis_tdata[16 +: DIST_BITS];
        ram_waddr = {in_y[YB-1:0], in_x[XB-1:0]};
        ax        = x_reg[XB-1:0];
        ay        = y_reg[YB-1:0];
        if (state_reg == ST_NEIGH && nidx_reg != 4'(NUM_NEIGH))
        begin
            ax = nx[XB-1:0];
            ay = ny[YB-1:0];
        end
        ram_raddr = {ay, ax};
        if (state_reg == ST_IDLE)
        begin
            ram_raddr = {in_y[YB-1:0], in_x[XB-1:0]};
            ram_we    = in_acc && req == REQ_WRITE && in_inside;
        end
        else if (state_reg == ST_WRITE)
        begin
            ram_waddr = {y_reg[YB-1:0], x_reg[XB-1:0]};
            if (phase_reg == PH_NEAR || phase_reg == PH_FAR)
            begin
                ram_we    = (ram_rdata != '0);
                ram_wdata = wo_sat;
            end
            else
            begin
                // The last neighbour read was already folded into min_reg in ST_NEIGH.
                ram_we    = cen_nz_reg;
                ram_wdata = (pend_reg && cand < min_reg) ? DIST_BITS'(cand)
                          : (min_reg > (DIST_BITS+2)'(DMAX)) ? DMAX
                          : DIST_BITS'(min_reg);
            end
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_done_next  = out_done_reg;
        rd_pend_next   = 1'b0;
        rd_in_next     = rd_in_reg;
        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;
        if (in_acc && req == REQ_READ)
        begin
            rd_pend_next = 1'b1;
            rd_in_next   = in_inside;
        end
        if (rd_pend_reg)
        begin
            out_valid_next = 1'b1;
            out_data_next  = rd_in_reg ? 16'(ram_rdata) : 16'd0;
            out_done_next  = 1'b0;
        end
        if (status.done)
        begin
            out_valid_next = 1'b1;
            out_data_next  = 16'd0;
            out_done_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_NEAR;
            out_valid_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
            rd_pend_reg   <= rd_pend_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        y_reg        <= y_next;
        nidx_reg     <= nidx_next;
        pidx_reg     <= pidx_next;
        min_reg      <= min_next;
        cen_nz_reg   <= cen_nz_next;
        out_data_reg <= out_data_next;
        out_done_reg <= out_done_next;
        rd_in_reg    <= rd_in_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_done_reg;

endmodule

[sv/cdt_checker.sv]
// ============================================================================
// Chamfer distance transform port checker
// Watches the top-level ports for handshake and result ordering rules.
// ============================================================================
module cdt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tuser
);
    import cdt_pkg::*;

    // A result waiting on the output holds its data.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output data changed while stalled");

    // A completion transaction carries zero data.
    a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 16'd0)
        else $error("completion carries data");

    // A read request is answered by a valid result that is not a completion.
    a_read_lat: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == REQ_READ
        |=> ##1 m_axis_tvalid && !m_axis_tuser)
        else $error("read result missing");

    // No new request is taken while a result waits.
    a_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("request accepted while result pending");

endmodule

bind chamfer_distance_transform_5x5 cdt_checker u_cdt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
